// ===== rtl/linear_adsr_envelope_assert.svh =====
// ----------------------------------------------------------------------------
// linear adsr envelope assertion macros
// Concurrent assertion wrappers clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ADSR_ENVELOPE_ASSERT_SVH
`define LINEAR_ADSR_ENVELOPE_ASSERT_SVH

// condition that holds at every edge out of reset
`define ADSR_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("adsr invariant violated");

// same-cycle implication
`define ADSR_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("adsr implication violated");

// next-cycle implication
`define ADSR_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("adsr sequence violated");

`endif

// ===== rtl/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared constants, codes and types of the linear adsr envelope.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int DEF_SAMPLE_BITS     = 24;
    localparam int DEF_LEVEL_FRAC_BITS = 23;

    localparam int CFG_W    = 24;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int GAIN_W   = 9;
    localparam int GAIN_SH  = 8;
    // wide enough to compare the sustain register against any full scale
    localparam int CMP_W    = 33;

    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_RELEASE = 2'd2;
    localparam logic [1:0] REG_SUSTAIN = 2'd3;

    localparam logic [CFG_W-1:0] RST_ATTACK  = 24'd24000;
    localparam logic [CFG_W-1:0] RST_DECAY   = 24'd24000;
    localparam logic [CFG_W-1:0] RST_RELEASE = 24'd24000;
    localparam logic [CFG_W-1:0] RST_SUSTAIN = 24'd4194304;
    localparam logic [GAIN_W-1:0] RST_GAIN   = 9'd256;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_ON    = 2'd1;
    localparam logic [1:0] KIND_OFF   = 2'd2;

    localparam logic [2:0] PH_OFF     = 3'd0;
    localparam logic [2:0] PH_ATTACK  = 3'd1;
    localparam logic [2:0] PH_DECAY   = 3'd2;
    localparam logic [2:0] PH_SUSTAIN = 3'd3;
    localparam logic [2:0] PH_RELEASE = 3'd4;

    typedef struct packed {
        logic ld_first;
        logic ld_second;
    } lane_ctrl_t;

endpackage

// ===== rtl/adsr_div.sv =====
// ----------------------------------------------------------------------------
// adsr_div
// Restoring divider lane, one quotient bit per cycle, for the step values.
// ----------------------------------------------------------------------------
module adsr_div #(
    parameter int NUM_W = adsr_pkg::DEF_LEVEL_FRAC_BITS + 1,
    parameter int DEN_W = adsr_pkg::CFG_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    import adsr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // shift in the next numerator bit, subtract when the divisor fits
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/adsr_lane.sv =====
// ----------------------------------------------------------------------------
// adsr_lane
// One channel scaling lane: sample times level, then times gain, rounded.
// ----------------------------------------------------------------------------
module adsr_lane #(
    parameter int SAMPLE_BITS     = adsr_pkg::DEF_SAMPLE_BITS,
    parameter int LEVEL_FRAC_BITS = adsr_pkg::DEF_LEVEL_FRAC_BITS
) (
    input  logic                          aclk,
    input  adsr_pkg::lane_ctrl_t          ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [LEVEL_FRAC_BITS:0]      level,
    input  logic [adsr_pkg::GAIN_W-1:0]   gain,
    output logic                          neg,
    output logic [SAMPLE_BITS:0]          mag
);
    import adsr_pkg::*;

    localparam int P1_W = SAMPLE_BITS + LEVEL_FRAC_BITS + 1;
    localparam int P2_W = SAMPLE_BITS + GAIN_W;
    localparam logic [P1_W:0] HALF1 =
        {{(P1_W + 1 - LEVEL_FRAC_BITS){1'b0}}, 1'b1, {(LEVEL_FRAC_BITS - 1){1'b0}}};
    localparam logic [P2_W:0] HALF2 =
        {{(P2_W + 1 - GAIN_SH){1'b0}}, 1'b1, {(GAIN_SH - 1){1'b0}}};

    logic [SAMPLE_BITS-1:0] smp_mag;
    logic [P1_W-1:0]        prod1_reg;
    logic                   neg1_reg;
    logic [P1_W:0]          sum1;
    logic [SAMPLE_BITS-1:0] t_mag;
    logic [P2_W-1:0]        prod2_reg;
    logic                   neg2_reg;
    logic [P2_W:0]          sum2;

    // magnitude of the most negative sample still fits unsigned
    assign smp_mag = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);

    // round half away from zero on magnitudes, sign reapplied at merge
    assign sum1  = {1'b0, prod1_reg} + HALF1;
    assign t_mag = sum1[LEVEL_FRAC_BITS +: SAMPLE_BITS];
    assign sum2  = {1'b0, prod2_reg} + HALF2;

    always_ff @(posedge aclk) begin
        if (ctrl.ld_first) begin
            prod1_reg <= P1_W'(smp_mag) * P1_W'(level);
            neg1_reg  <= sample[SAMPLE_BITS-1];
        end
        if (ctrl.ld_second) begin
            prod2_reg <= P2_W'(t_mag) * P2_W'(gain);
            neg2_reg  <= neg1_reg;
        end
    end

    assign neg = neg2_reg;
    assign mag = sum2[GAIN_SH +: (SAMPLE_BITS + 1)];

endmodule

// ===== rtl/adsr_merge.sv =====
// ----------------------------------------------------------------------------
// adsr_merge
// Joins both lanes, saturates to the sample range and holds the result.
// ----------------------------------------------------------------------------
module adsr_merge #(
    parameter int SAMPLE_BITS = adsr_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic                          neg_l,
    input  logic [SAMPLE_BITS:0]          mag_l,
    input  logic                          neg_r,
    input  logic [SAMPLE_BITS:0]          mag_r,
    output logic                          free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out
);
    import adsr_pkg::*;

    localparam logic [SAMPLE_BITS:0] MAX_POS = {2'b00, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS:0] MAX_NEG = {2'b01, {(SAMPLE_BITS - 1){1'b0}}};

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [SAMPLE_BITS-1:0] left_reg;
    logic [SAMPLE_BITS-1:0] right_reg;

    function automatic logic [SAMPLE_BITS-1:0] sat_mag(input logic n,
                                                       input logic [SAMPLE_BITS:0] m);
        logic [SAMPLE_BITS:0] negm;
        negm = -m;
        if (!n) begin
            sat_mag = (m > MAX_POS) ? MAX_POS[SAMPLE_BITS-1:0] : m[SAMPLE_BITS-1:0];
        end else begin
            sat_mag = (m > MAX_NEG) ? MAX_NEG[SAMPLE_BITS-1:0] : negm[SAMPLE_BITS-1:0];
        end
    endfunction

    assign free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            left_reg  <= sat_mag(neg_l, mag_l);
            right_reg <= sat_mag(neg_r, mag_r);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = $signed(left_reg);
    assign m_right_out = $signed(right_reg);

endmodule

// ===== rtl/linear_adsr_envelope.sv =====
// frame: samples registered, two multiply stages, then the output register when free
// a new frame is taken only once the last is in the output, paced by the two-step multiply
// note on: waits on the bit-serial step dividers; note off: release phase in the next cycle
// a held result does not block the next transfer until its own result is due
// synchronous active-low reset: registers to defaults, level 0, phase off, gain 1.0
// ----------------------------------------------------------------------------
// linear_adsr_envelope
// Linear attack/decay/sustain/release envelope scaling a stereo stream.
// ----------------------------------------------------------------------------
`include "linear_adsr_envelope_assert.svh"

module linear_adsr_envelope #(
    parameter int SAMPLE_BITS     = adsr_pkg::DEF_SAMPLE_BITS,
    parameter int LEVEL_FRAC_BITS = adsr_pkg::DEF_LEVEL_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [adsr_pkg::ADDR_W-1:0]       paddr,
    input  logic [adsr_pkg::DATA_W-1:0]       pwdata,
    output logic [adsr_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic signed [SAMPLE_BITS-1:0]     s_left_in,
    input  logic signed [SAMPLE_BITS-1:0]     s_right_in,
    input  logic [adsr_pkg::GAIN_W-1:0]       s_velocity,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_BITS-1:0]     m_left_out,
    output logic signed [SAMPLE_BITS-1:0]     m_right_out
);
    import adsr_pkg::*;

    localparam int STEP_W = LEVEL_FRAC_BITS + 1;
    localparam int LVL_W  = LEVEL_FRAC_BITS + 2;
    localparam int EXT_W  = LEVEL_FRAC_BITS + 3;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam logic [STEP_W-1:0]       ONE_STEP = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
    localparam logic signed [LVL_W-1:0] ONE_LVL  = {2'b01, {LEVEL_FRAC_BITS{1'b0}}};
    localparam logic signed [EXT_W-1:0] ONE_EXT  = {3'b001, {LEVEL_FRAC_BITS{1'b0}}};
    localparam logic [CMP_W-1:0]        ONE_CMP  = CMP_W'(1) << LEVEL_FRAC_BITS;

    // configuration
    logic [CFG_W-1:0] attack_reg;
    logic [CFG_W-1:0] decay_reg;
    logic [CFG_W-1:0] release_reg;
    logic [CFG_W-1:0] sustain_reg;
    logic             apb_wr;

    // envelope state
    logic [2:0]              state_reg, state_next;
    logic [2:0]              phase_reg, phase_next;
    logic signed [LVL_W-1:0] level_reg, level_next;
    logic [STEP_W-1:0]       atk_step_reg, atk_step_next;
    logic [STEP_W-1:0]       dec_step_reg, dec_step_next;
    logic [STEP_W-1:0]       rel_step_reg, rel_step_next;
    logic [GAIN_W-1:0]       gain_reg, gain_next;
    logic signed [SAMPLE_BITS-1:0] smp_l_reg;
    logic signed [SAMPLE_BITS-1:0] smp_r_reg;

    logic                    s_fire;
    logic                    div_start;
    logic                    div_done;
    logic                    dec_done;
    logic                    rel_done;
    logic [STEP_W-1:0]       atk_q, dec_q, rel_q;
    logic [CMP_W-1:0]        sus_cmp;
    logic [STEP_W-1:0]       sus_q;
    logic [CFG_W-1:0]        atk_den, dec_den, rel_den;

    logic signed [EXT_W-1:0] lvl_ext;
    logic signed [EXT_W-1:0] sus_ext;
    logic signed [EXT_W-1:0] atk_sum, dec_diff, rel_diff;
    logic signed [LVL_W-1:0] adv_level;
    logic [2:0]              adv_phase;

    lane_ctrl_t              lane_ctrl;
    logic                    neg_l, neg_r;
    logic [SAMPLE_BITS:0]    mag_l, mag_r;
    logic                    out_load;
    logic                    out_free;

    // ------------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= RST_ATTACK;
            decay_reg   <= RST_DECAY;
            release_reg <= RST_RELEASE;
            sustain_reg <= RST_SUSTAIN;
        end else if (apb_wr) begin
            unique case (paddr[3:2])
                REG_ATTACK:  attack_reg  <= pwdata[CFG_W-1:0];
                REG_DECAY:   decay_reg   <= pwdata[CFG_W-1:0];
                REG_RELEASE: release_reg <= pwdata[CFG_W-1:0];
                REG_SUSTAIN: sustain_reg <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ATTACK:  prdata = DATA_W'(attack_reg);
            REG_DECAY:   prdata = DATA_W'(decay_reg);
            REG_RELEASE: prdata = DATA_W'(release_reg);
            REG_SUSTAIN: prdata = DATA_W'(sustain_reg);
        endcase
    end

    // ------------------------------------------------------------------------
    // step dividers, one lane per ramp: attack, decay, release
    // ------------------------------------------------------------------------
    assign sus_cmp = (CMP_W'(sustain_reg) > ONE_CMP) ? ONE_CMP : CMP_W'(sustain_reg);
    assign sus_q   = sus_cmp[STEP_W-1:0];

    // a zero length counts as one sample
    assign atk_den = (attack_reg  == '0) ? CFG_W'(1) : attack_reg;
    assign dec_den = (decay_reg   == '0) ? CFG_W'(1) : decay_reg;
    assign rel_den = (release_reg == '0) ? CFG_W'(1) : release_reg;

    adsr_div #(.NUM_W(STEP_W), .DEN_W(CFG_W)) u_div_atk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (ONE_STEP),
        .den     (atk_den),
        .done    (div_done),
        .quo     (atk_q)
    );

    adsr_div #(.NUM_W(STEP_W), .DEN_W(CFG_W)) u_div_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (ONE_STEP - sus_q),
        .den     (dec_den),
        .done    (dec_done),
        .quo     (dec_q)
    );

    adsr_div #(.NUM_W(STEP_W), .DEN_W(CFG_W)) u_div_rel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (sus_q),
        .den     (rel_den),
        .done    (rel_done),
        .quo     (rel_q)
    );

    // ------------------------------------------------------------------------
    // envelope advance for one frame
    // ------------------------------------------------------------------------
    assign lvl_ext  = EXT_W'(level_reg);
    assign sus_ext  = $signed({2'b00, sus_q});
    assign atk_sum  = lvl_ext + $signed({2'b00, atk_step_reg});
    assign dec_diff = lvl_ext - $signed({2'b00, dec_step_reg});
    assign rel_diff = lvl_ext - $signed({2'b00, rel_step_reg});

    always_comb begin
        adv_level = level_reg;
        adv_phase = phase_reg;
        case (phase_reg)
            PH_ATTACK: begin
                if (atk_sum >= ONE_EXT) begin
                    adv_level = ONE_LVL;
                    adv_phase = PH_DECAY;
                end else begin
                    adv_level = LVL_W'(atk_sum);
                end
            end
            PH_DECAY: begin
                if (dec_diff <= sus_ext) begin
                    adv_level = LVL_W'(sus_ext);
                    adv_phase = PH_SUSTAIN;
                end else begin
                    adv_level = LVL_W'(dec_diff);
                end
            end
            PH_SUSTAIN: begin
                adv_level = LVL_W'(sus_ext);
            end
            PH_RELEASE: begin
                if (rel_diff <= EXT_W'(0)) begin
                    adv_level = '0;
                    adv_phase = PH_OFF;
                end else begin
                    adv_level = LVL_W'(rel_diff);
                end
            end
            default: begin
                adv_level = level_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        level_next    = level_reg;
        atk_step_next = atk_step_reg;
        dec_step_next = dec_step_reg;
        rel_step_next = rel_step_reg;
        gain_next     = gain_reg;
        div_start     = 1'b0;
        lane_ctrl     = '0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_kind)
                        KIND_FRAME: begin
                            level_next = adv_level;
                            phase_next = adv_phase;
                            state_next = ST_MUL1;
                        end
                        KIND_ON: begin
                            div_start  = 1'b1;
                            gain_next  = s_velocity;
                            state_next = ST_DIV;
                        end
                        KIND_OFF: begin
                            phase_next = PH_RELEASE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    // steps never drop below one lsb
                    atk_step_next = (atk_q == '0) ? STEP_W'(1) : atk_q;
                    dec_step_next = (dec_q == '0) ? STEP_W'(1) : dec_q;
                    rel_step_next = (rel_q == '0) ? STEP_W'(1) : rel_q;
                    level_next    = -$signed({1'b0, atk_step_next});
                    phase_next    = PH_ATTACK;
                    state_next    = ST_IDLE;
                end
            end
            ST_MUL1: begin
                lane_ctrl.ld_first = 1'b1;
                state_next         = ST_MUL2;
            end
            ST_MUL2: begin
                lane_ctrl.ld_second = 1'b1;
                state_next          = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_OFF;
            level_reg    <= '0;
            atk_step_reg <= '0;
            dec_step_reg <= '0;
            rel_step_reg <= '0;
            gain_reg     <= RST_GAIN;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            level_reg    <= level_next;
            atk_step_reg <= atk_step_next;
            dec_step_reg <= dec_step_next;
            rel_step_reg <= rel_step_next;
            gain_reg     <= gain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            smp_l_reg <= s_left_in;
            smp_r_reg <= s_right_in;
        end
    end

    // ------------------------------------------------------------------------
    // channel lanes and merge
    // ------------------------------------------------------------------------
    // level is never negative once a frame has advanced it
    adsr_lane #(.SAMPLE_BITS(SAMPLE_BITS), .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_lane_l (
        .aclk   (aclk),
        .ctrl   (lane_ctrl),
        .sample (smp_l_reg),
        .level  (level_reg[STEP_W-1:0]),
        .gain   (gain_reg),
        .neg    (neg_l),
        .mag    (mag_l)
    );

    adsr_lane #(.SAMPLE_BITS(SAMPLE_BITS), .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_lane_r (
        .aclk   (aclk),
        .ctrl   (lane_ctrl),
        .sample (smp_r_reg),
        .level  (level_reg[STEP_W-1:0]),
        .gain   (gain_reg),
        .neg    (neg_r),
        .mag    (mag_r)
    );

    adsr_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (out_load),
        .neg_l       (neg_l),
        .mag_l       (mag_l),
        .neg_r       (neg_r),
        .mag_r       (mag_r),
        .free        (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out)
    );

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `ADSR_ALWAYS(a_level_max, level_reg <= ONE_LVL)
    `ADSR_IMPLIES(a_div_in_div, div_done, (state_reg == ST_DIV) && dec_done && rel_done)
    `ADSR_NEXT(a_fin_out, (state_reg == ST_FIN) && out_free, (state_reg == ST_IDLE) && m_valid)
    `ADSR_NEXT(a_off_hold, s_fire && (s_kind == KIND_OFF), phase_reg == PH_RELEASE)

endmodule
